FILE: hdl/assert_macros.svh
// Assertion macros shared by the segment LCD frame writer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/slcd_pkg.sv
// Types, constants and glyph table for the segment LCD frame writer.
package slcd_pkg;

	localparam int SEGMENTS     = 10;
	localparam int COMMONS      = 4;
	localparam int ADDRESS_BITS = 6;

	localparam int FRAME_BITS = 3 + ADDRESS_BITS + SEGMENTS * COMMONS;
	localparam int CMD_BITS   = 12;
	localparam int CNT_W      = $clog2(FRAME_BITS + 1);
	localparam int CONV_STEPS = 10;

	localparam logic [2:0] HDR_DATA = 3'b101;
	localparam logic [2:0] HDR_CMD  = 3'b100;

	localparam logic [2:0] MODE_ALL  = 3'd0;
	localparam logic [2:0] MODE_TEMP = 3'd1;
	localparam logic [2:0] MODE_TIME = 3'd2;
	localparam logic [2:0] MODE_BATT = 3'd3;
	localparam logic [2:0] MODE_CMD  = 3'd4;

	typedef logic [COMMONS-1:0] nibble_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       flag;
		logic [9:0] temperature_tenths;
		logic [5:0] minutes;
		logic [4:0] hours;
		logic [7:0] command_code;
	} in_item_t;

	// One queued frame: bits sent MSB first, command frames left-aligned.
	typedef struct packed {
		logic [FRAME_BITS-1:0] bits;
		logic                  kind;
		logic                  unk;
	} frame_t;

	// Three nibbles of a digit glyph, first nibble in the top bits.
	function automatic logic [3*COMMONS-1:0] glyph_row(input logic [3:0] d);
		logic [3*COMMONS-1:0] r;
		case (d)
			4'd0: r = 12'h6a6;
			4'd1: r = 12'h600;
			4'd2: r = 12'h2e4;
			4'd3: r = 12'h6e0;
			4'd4: r = 12'h642;
			4'd5: r = 12'h4e2;
			4'd6: r = 12'h4e6;
			4'd7: r = 12'h620;
			4'd8: r = 12'h6e6;
			4'd9: r = 12'h6e2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/segment_lcd_frame_writer.sv
// Top level of the segment LCD frame writer: ports, register and sub-block wiring.

// Segment LCD frame writer. Each input beat produces one serial frame, one
// output beat per line bit; modes 0 to 3 also update a 10 x 4-bit segment
// map. Modes 0 to 3 and the unknown modes 5 to 7 give a 49-beat data frame
// (header 101, the start address, then the map nibbles from index 0, each
// MSB first); mode 4 gives a 12-beat command frame (header 100, the command
// byte, a 0 bit). m_tlast marks the last beat of each frame. The front end
// takes each item through accept, ten double-dabble steps for the decimal
// digits, and a step that updates the map and queues the frame and waits
// there while the queue is full; it takes no new item until it is done. A
// two-entry frame queue lets it run ahead of the serialiser. The serialiser
// emits one bit per cycle while m_tready lets it, and loads the next frame
// in the cycle its last bit enters the output register, so while m_tready
// is held high and frames are queued they go out back to back.
// cfg_data sets the start address (reset 9); it is always ready and should
// only be written while the block is idle.
module segment_lcd_frame_writer
	import slcd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// Configuration write: start_address.
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [ADDRESS_BITS-1:0] cfg_data,
	// Input beats.
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// s_tdata from bit 0: flag[0], temperature_tenths[10:1], minutes[16:11],
	// hours[21:17], command_code[29:22], zero fill [31:30]
	input  logic [31:0]             s_tdata,
	// s_tuser: mode[2:0]
	input  logic [2:0]              s_tuser,
	// Output beats.
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// m_tdata from bit 0: serial_bit[0], zero fill [7:1]
	output logic [7:0]              m_tdata,
	// m_tuser from bit 0: frame_kind[0], unknown_mode[1]
	output logic [1:0]              m_tuser,
	output logic                    m_tlast
);

	logic [ADDRESS_BITS-1:0] start_address_q;
	in_item_t                item;
	logic                    push, full, pop, empty;
	frame_t                  push_frame, head;
	logic                    out_bit, out_kind, out_unk;

	// Register write port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_address_q <= ADDRESS_BITS'(9);
		end else if (cfg_valid) begin
			start_address_q <= cfg_data;
		end
	end

	// Unpack the input beat.
	assign item.mode               = s_tuser;
	assign item.flag               = s_tdata[0];
	assign item.temperature_tenths = s_tdata[10:1];
	assign item.minutes            = s_tdata[16:11];
	assign item.hours              = s_tdata[21:17];
	assign item.command_code       = s_tdata[29:22];

	slcd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_item       (item),
		.start_address (start_address_q),
		.push          (push),
		.push_frame    (push_frame),
		.full          (full)
	);

	slcd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	slcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_bit   (out_bit),
		.out_kind  (out_kind),
		.out_last  (m_tlast),
		.out_unk   (out_unk)
	);

	assign m_tdata = {7'd0, out_bit};
	assign m_tuser = {out_unk, out_kind};

endmodule

FILE: hdl/slcd_front.sv
// Front end: accepts items, converts digits, updates the segment map, queues frames.
`include "assert_macros.svh"

module slcd_front
	import slcd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  in_item_t                in_item,
	input  logic [ADDRESS_BITS-1:0] start_address,
	output logic                    push,
	output frame_t                  push_frame,
	input  logic                    full
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CONV  = 3'b010,
		ST_APPLY = 3'b100
	} fstate_t;

	fstate_t    state_q;
	logic [3:0] step_q;
	in_item_t   item_q;
	logic [9:0] sh_q;
	logic [11:0] bcd_q;
	nibble_t    map_q [SEGMENTS];
	nibble_t    map_n [SEGMENTS];

	logic [11:0] bcd_adj;
	logic [4:0]  hadj;
	logic [4:0]  hunit;
	logic [3*COMMONS-1:0] g_u, g_t, g_h;
	logic        map_wr;
	logic        unk;

	assign in_ready = (state_q == ST_IDLE);

	// Double dabble step: add 3 to digits of 5 or more, then shift.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
			                                              : bcd_q[4*i +: 4];
		end
	end

	assign hadj  = (item_q.hours > 5'd12) ? item_q.hours - 5'd12 : item_q.hours;
	assign hunit = (hadj > 5'd9) ? hadj - 5'd10 : hadj;

	assign g_u = glyph_row(bcd_q[3:0]);
	assign g_t = glyph_row(bcd_q[7:4]);
	assign g_h = (item_q.mode == MODE_TIME) ? glyph_row(hunit[3:0]) : glyph_row(bcd_q[11:8]);

	assign unk    = (item_q.mode > MODE_CMD);
	assign map_wr = (item_q.mode < MODE_CMD);

	always_comb begin
		for (int i = 0; i < SEGMENTS; i++) map_n[i] = map_q[i];
		case (item_q.mode)
			MODE_ALL: begin
				for (int i = 0; i < SEGMENTS; i++) map_n[i] = {COMMONS{item_q.flag}};
			end
			MODE_TEMP, MODE_TIME: begin
				map_n[1] = g_u[11:8];
				map_n[2] = g_u[7:4];
				map_n[3] = g_u[3:0];
				map_n[4] = g_t[11:8];
				map_n[5] = g_t[7:4];
				map_n[6] = g_t[3:0];
				map_n[7] = g_h[11:8];
				map_n[8] = g_h[7:4];
				map_n[9] = g_h[3:0];
				if (item_q.mode == MODE_TEMP) begin
					map_n[0] = map_q[0] | 4'b1110;
					map_n[3][3] = 1'b1;
					map_n[4][3] = 1'b1;
				end else begin
					map_n[9][3] = (hadj > 5'd9);
					map_n[7][3] = 1'b1;
				end
			end
			MODE_BATT: begin
				map_n[1][3] = item_q.flag;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		push_frame = '0;
		push_frame.kind = (item_q.mode == MODE_CMD);
		push_frame.unk  = unk;
		if (item_q.mode == MODE_CMD) begin
			push_frame.bits[FRAME_BITS-1 -: CMD_BITS] = {HDR_CMD, item_q.command_code, 1'b0};
		end else begin
			push_frame.bits[FRAME_BITS-1 -: 3] = HDR_DATA;
			push_frame.bits[FRAME_BITS-4 -: ADDRESS_BITS] = start_address;
			for (int i = 0; i < SEGMENTS; i++) begin
				push_frame.bits[(SEGMENTS-1-i)*COMMONS +: COMMONS] = map_n[i];
			end
		end
	end

	assign push = (state_q == ST_APPLY) && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			for (int i = 0; i < SEGMENTS; i++) map_q[i] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CONV;
						step_q  <= '0;
					end
				end
				ST_CONV: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'(CONV_STEPS - 1)) state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (!full) begin
						state_q <= ST_IDLE;
						if (map_wr) begin
							for (int i = 0; i < SEGMENTS; i++) map_q[i] <= map_n[i];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			item_q <= in_item;
			sh_q   <= (in_item.mode == MODE_TIME) ? {4'd0, in_item.minutes}
			                                      : in_item.temperature_tenths;
			bcd_q  <= '0;
		end else if (state_q == ST_CONV) begin
			bcd_q <= {bcd_adj[10:0], sh_q[9]};
			sh_q  <= {sh_q[8:0], 1'b0};
		end
	end

	`ASSERT_NEXT(a_f_conv_len, clk, arst_n, state_q == ST_CONV && step_q == 4'(CONV_STEPS - 1), state_q == ST_APPLY, "conversion did not end after its last step")
	`ASSERT_IMPL(a_f_step_range, clk, arst_n, state_q == ST_CONV, step_q < 4'(CONV_STEPS), "conversion step out of range")

endmodule

FILE: hdl/slcd_queue.sv
// Two-entry frame queue between front and back end.
`include "assert_macros.svh"

module slcd_queue
	import slcd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t push_frame,
	output logic   full,
	input  logic   pop,
	output frame_t head,
	output logic   empty
);

	frame_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_frame;
	end

	`ASSERT_IMPL(a_q_no_overflow, clk, arst_n, push && !pop, count_q != 2'd2, "frame queue overflow")
	`ASSERT_IMPL(a_q_no_underflow, clk, arst_n, pop, count_q != 2'd0, "frame queue underflow")

endmodule

FILE: hdl/slcd_back.sv
// Back end: shifts queued frames out one bit per beat through an output register.
`include "assert_macros.svh"

module slcd_back
	import slcd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  frame_t head,
	input  logic   empty,
	output logic   pop,
	output logic   out_valid,
	input  logic   out_ready,
	output logic   out_bit,
	output logic   out_kind,
	output logic   out_last,
	output logic   out_unk
);

	logic                  busy_q;
	logic [FRAME_BITS-1:0] shift_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  kind_q;
	logic                  unk_q;
	logic                  valid_q;
	logic                  bit_q, okind_q, last_q, ounk_q;

	logic out_free;
	logic emit;

	assign out_free = !valid_q || out_ready;
	assign emit     = busy_q && out_free;
	assign pop      = !empty && (!busy_q || (emit && cnt_q == CNT_W'(1)));

	assign out_valid = valid_q;
	assign out_bit   = bit_q;
	assign out_kind  = okind_q;
	assign out_last  = last_q;
	assign out_unk   = ounk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (out_free) valid_q <= emit;
			// a load takes over from the last bit of the previous frame
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= head.kind ? CNT_W'(CMD_BITS) : CNT_W'(FRAME_BITS);
			end else if (emit) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				busy_q <= (cnt_q != CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			bit_q   <= shift_q[FRAME_BITS-1];
			last_q  <= (cnt_q == CNT_W'(1));
			okind_q <= kind_q;
			ounk_q  <= unk_q;
		end
		if (pop) begin
			shift_q <= head.bits;
			kind_q  <= head.kind;
			unk_q   <= head.unk;
		end else if (emit) begin
			shift_q <= {shift_q[FRAME_BITS-2:0], 1'b0};
		end
	end

	`ASSERT_IMPL(a_b_count, clk, arst_n, busy_q, cnt_q != '0 && cnt_q <= CNT_W'(FRAME_BITS), "bit count out of range while busy")

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the segment LCD frame writer.
module tb;
	import slcd_pkg::*;

	// Mode codes outside the package list; all give a flagged data frame.
	localparam logic [2:0] MODE_UNK_LO  = 3'd5;
	localparam logic [2:0] MODE_UNK_MID = 3'd6;
	localparam logic [2:0] MODE_UNK_HI  = 3'd7;

	localparam logic [ADDRESS_BITS-1:0] START_ADDR_RESET = 6'd9;

	localparam int NUM_DIRECTED = 24;
	localparam int ITEMS_PER_PHASE = 72;
	localparam int NUM_PHASES = 4;
	// Tail after the last beat: longer than the accept-to-first-bit latency.
	localparam int TAIL_CYCLES = 64;
	// Worst case per item is 49 beats, each after the longest stall, plus the
	// sender gap and the front end, for ~310 items.
	localparam int CYCLE_LIMIT = 600000;

	// One whole frame as the line sees it, first bit in bit len-1.
	typedef struct packed {
		logic [FRAME_BITS-1:0] bits;
		logic [5:0]            len;
		logic                  kind;
		logic                  unk;
	} lcd_frame_t;

	// One output beat, in the order the fields are compared.
	typedef struct packed {
		logic line_bit;
		logic kind;
		logic last;
		logic unk;
	} line_beat_t;

	// Directed stimulus row; when typed is set, want gives the frame bits outright.
	typedef struct packed {
		in_item_t              item;
		logic                  typed;
		logic [FRAME_BITS-1:0] want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [ADDRESS_BITS-1:0] cfg_data;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [31:0]             s_tdata;
	logic [2:0]              s_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [7:0]              m_tdata;
	logic [1:0]              m_tuser;
	logic                    m_tlast;

	// Shadow of the display memory and the start address register.
	nibble_t                 seg_shadow [SEGMENTS];
	logic [ADDRESS_BITS-1:0] addr_shadow;

	line_beat_t pending_beats [$];
	stim_row_t  dir_rows [NUM_DIRECTED];
	int         mismatches = 0;
	int         cycle_count = 0;
	bit         send_calm = 1'b0;

	segment_lcd_frame_writer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: watchdog expired, %0d beats still due", $time, pending_beats.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Three nibbles of a digit shape, leftmost nibble in the top bits.
	function automatic logic [11:0] digit_shape(input int d);
		logic [11:0] s;
		case (d)
			0: s = 12'h6a6;
			1: s = 12'h600;
			2: s = 12'h2e4;
			3: s = 12'h6e0;
			4: s = 12'h642;
			5: s = 12'h4e2;
			6: s = 12'h4e6;
			7: s = 12'h620;
			8: s = 12'h6e6;
			default: s = 12'h6e2;
		endcase
		return s;
	endfunction

	// Only the units digit of value is drawn, over nibbles first..first+2.
	function automatic void draw_digit(input int first, input int value);
		logic [11:0] s;
		s = digit_shape(value % 10);
		seg_shadow[first]     = s[11:8];
		seg_shadow[first + 1] = s[7:4];
		seg_shadow[first + 2] = s[3:0];
	endfunction

	// Applies one item to the shadow map and returns the frame it sends.
	function automatic lcd_frame_t render_frame(input in_item_t it);
		lcd_frame_t f;
		int         hr;
		int         i;
		f.bits = '0;
		f.len  = 6'(FRAME_BITS);
		f.kind = 1'b0;
		f.unk  = 1'b0;
		if (it.mode == MODE_CMD) begin
			// Command frame: map untouched, trailing 0 after the code.
			f.bits = FRAME_BITS'({HDR_CMD, it.command_code, 1'b0});
			f.len  = 6'(CMD_BITS);
			f.kind = 1'b1;
			return f;
		end
		case (it.mode)
			MODE_ALL: begin
				for (i = 0; i < SEGMENTS; i++)
					seg_shadow[i] = it.flag ? 4'hf : 4'h0;
			end
			MODE_TEMP: begin
				draw_digit(1, int'(it.temperature_tenths));
				draw_digit(4, int'(it.temperature_tenths) / 10);
				draw_digit(7, int'(it.temperature_tenths) / 100);
				// degree/point marks; bit 0 of nibble 0 is left as it was
				seg_shadow[0][3:1] = 3'b111;
				seg_shadow[3][3]   = 1'b1;
				seg_shadow[4][3]   = 1'b1;
			end
			MODE_TIME: begin
				draw_digit(1, int'(it.minutes));
				draw_digit(4, int'(it.minutes) / 10);
				hr = int'(it.hours);
				if (hr > 12)
					hr = hr - 12;
				draw_digit(7, hr);
				seg_shadow[9][3] = (hr > 9);
				seg_shadow[7][3] = 1'b1;
			end
			MODE_BATT: begin
				seg_shadow[1][3] = it.flag;
			end
			default: begin
				f.unk = 1'b1;
			end
		endcase
		f.bits = {HDR_DATA, addr_shadow, {(SEGMENTS * COMMONS){1'b0}}};
		for (i = 0; i < SEGMENTS; i++)
			f.bits[COMMONS * (SEGMENTS - 1 - i) +: COMMONS] = seg_shadow[i];
		return f;
	endfunction

	function automatic stim_row_t mk_row(input logic [2:0] mode, input logic flag,
			input logic [9:0] temp, input logic [5:0] mins, input logic [4:0] hrs,
			input logic [7:0] code, input logic typed, input logic [FRAME_BITS-1:0] want);
		stim_row_t r;
		r.item.mode               = mode;
		r.item.flag               = flag;
		r.item.temperature_tenths = temp;
		r.item.minutes            = mins;
		r.item.hours              = hrs;
		r.item.command_code       = code;
		r.typed                   = typed;
		r.want                    = want;
		return r;
	endfunction

	// Drives one item, waits for its beat to be taken, then queues its frame.
	task automatic send_item(input in_item_t it, input logic typed,
			input logic [FRAME_BITS-1:0] want);
		int         gap;
		int         i;
		lcd_frame_t f;
		if ($urandom_range(0, 15) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.mode;
		s_tdata  <= {2'b00, it.command_code, it.hours, it.minutes,
			it.temperature_tenths, it.flag};
		do @(posedge clk); while (!s_tready);
		f = render_frame(it);
		if (typed)
			f.bits = want;
		for (i = int'(f.len) - 1; i >= 0; i--)
			pending_beats.push_back('{f.bits[i], f.kind, (i == 0), f.unk});
	endtask

	// Blocks until the last due beat has gone out.
	task automatic drain_frames();
		while (pending_beats.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_start_address(input logic [ADDRESS_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		addr_shadow  = value;
	endtask

	// Output side: random back-pressure per beat, with runs of none at all.
	initial begin : line_sink
		int         stall;
		bit         calm;
		line_beat_t got;
		line_beat_t want;
		calm = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 63) == 0)
				calm = !calm;
			stall = calm ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = '{m_tdata[0], m_tuser[0], m_tlast, m_tuser[1]};
			if (pending_beats.size() == 0) begin
				$display("%0t: beat with nothing due: bit/kind/last/unk %b", $time, got);
				mismatches++;
			end else begin
				want = pending_beats.pop_front();
				if (got !== want) begin
					$display("%0t: beat mismatch bit/kind/last/unk expected %b actual %b",
						$time, want, got);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		int       p;
		int       n;
		int       pick;
		in_item_t it;
		logic [ADDRESS_BITS-1:0] phase_addr;

		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= MODE_ALL;
		m_tready  <= 1'b0;
		for (n = 0; n < SEGMENTS; n++)
			seg_shadow[n] = 4'h0;
		addr_shadow = START_ADDR_RESET;

		// Directed rows. Typed frames are those readable straight off the
		// mode rules: blank map after reset, map all on/off, unknown and command
		// frames and the battery mark on a blank map. The rest go to the predictor.
		dir_rows[0]  = mk_row(MODE_BATT, 1'b0, 10'd0, 6'd0, 5'd0, 8'h00, 1'b1,
			{HDR_DATA, START_ADDR_RESET, 40'h00_0000_0000});
		dir_rows[1]  = mk_row(MODE_ALL, 1'b1, 10'd1023, 6'd63, 5'd31, 8'hff, 1'b1,
			{HDR_DATA, START_ADDR_RESET, 40'hff_ffff_ffff});
		// unknown mode: map kept, frame flagged
		dir_rows[2]  = mk_row(MODE_UNK_LO, 1'b0, 10'd0, 6'd0, 5'd0, 8'h00, 1'b1,
			{HDR_DATA, START_ADDR_RESET, 40'hff_ffff_ffff});
		dir_rows[3]  = mk_row(MODE_CMD, 1'b1, 10'd1023, 6'd63, 5'd31, 8'hff, 1'b1,
			FRAME_BITS'({HDR_CMD, 8'hff, 1'b0}));
		dir_rows[4]  = mk_row(MODE_CMD, 1'b0, 10'd0, 6'd0, 5'd0, 8'h00, 1'b1,
			FRAME_BITS'({HDR_CMD, 8'h00, 1'b0}));
		dir_rows[5]  = mk_row(MODE_ALL, 1'b0, 10'd512, 6'd32, 5'd16, 8'h80, 1'b1,
			{HDR_DATA, START_ADDR_RESET, 40'h00_0000_0000});
		dir_rows[6]  = mk_row(MODE_BATT, 1'b1, 10'd0, 6'd0, 5'd0, 8'h00, 1'b1,
			{HDR_DATA, START_ADDR_RESET, 40'h08_0000_0000});
		dir_rows[7]  = mk_row(MODE_TEMP, 1'b0, 10'd0, 6'd0, 5'd0, 8'h00, 1'b0, '0);
		// hundreds digit wraps: 1023 shows as 023
		dir_rows[8]  = mk_row(MODE_TEMP, 1'b1, 10'd1023, 6'd63, 5'd31, 8'hff, 1'b0, '0);
		dir_rows[9]  = mk_row(MODE_TEMP, 1'b0, 10'd999, 6'd0, 5'd0, 8'h00, 1'b0, '0);
		dir_rows[10] = mk_row(MODE_TEMP, 1'b0, 10'd123, 6'd0, 5'd0, 8'h00, 1'b0, '0);
		dir_rows[11] = mk_row(MODE_TIME, 1'b0, 10'd0, 6'd0, 5'd0, 8'h00, 1'b0, '0);
		dir_rows[12] = mk_row(MODE_TIME, 1'b1, 10'd1023, 6'd59, 5'd23, 8'hff, 1'b0, '0);
		// minutes past 59 still draw their tens digit
		dir_rows[13] = mk_row(MODE_TIME, 1'b0, 10'd0, 6'd63, 5'd12, 8'h00, 1'b0, '0);
		dir_rows[14] = mk_row(MODE_TIME, 1'b0, 10'd0, 6'd60, 5'd13, 8'h00, 1'b0, '0);
		// hours past 23: one subtraction of 12, tens mark on
		dir_rows[15] = mk_row(MODE_TIME, 1'b0, 10'd0, 6'd45, 5'd31, 8'h00, 1'b0, '0);
		dir_rows[16] = mk_row(MODE_TIME, 1'b0, 10'd0, 6'd7, 5'd22, 8'h00, 1'b0, '0);
		dir_rows[17] = mk_row(MODE_TIME, 1'b0, 10'd0, 6'd30, 5'd9, 8'h00, 1'b0, '0);
		dir_rows[18] = mk_row(MODE_BATT, 1'b0, 10'd1023, 6'd63, 5'd31, 8'hff, 1'b0, '0);
		dir_rows[19] = mk_row(MODE_UNK_MID, 1'b1, 10'd341, 6'd21, 5'd10, 8'h5a, 1'b0, '0);
		dir_rows[20] = mk_row(MODE_UNK_HI, 1'b1, 10'd1023, 6'd63, 5'd31, 8'hff, 1'b0, '0);
		dir_rows[21] = mk_row(MODE_CMD, 1'b0, 10'd0, 6'd0, 5'd0, 8'ha5, 1'b0, '0);
		dir_rows[22] = mk_row(MODE_ALL, 1'b1, 10'd0, 6'd0, 5'd0, 8'h00, 1'b0, '0);
		// temperature keeps bit 0 of nibble 0 from the all-on map
		dir_rows[23] = mk_row(MODE_TEMP, 1'b0, 10'd456, 6'd0, 5'd0, 8'h00, 1'b0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < NUM_DIRECTED; n++)
			send_item(dir_rows[n].item, dir_rows[n].typed, dir_rows[n].want);

		// Random phases, each at its own start address: both extremes first.
		for (p = 0; p < NUM_PHASES; p++) begin
			s_tvalid <= 1'b0;
			drain_frames();
			case (p)
				0: phase_addr = '0;
				1: phase_addr = '1;
				default: phase_addr = ADDRESS_BITS'($urandom_range(0, 63));
			endcase
			write_start_address(phase_addr);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(0, 15);
				if (pick < 2)
					it.mode = MODE_ALL;
				else if (pick < 5)
					it.mode = MODE_TEMP;
				else if (pick < 8)
					it.mode = MODE_TIME;
				else if (pick < 10)
					it.mode = MODE_BATT;
				else if (pick < 13)
					it.mode = MODE_CMD;
				else
					it.mode = 3'($urandom_range(MODE_UNK_LO, MODE_UNK_HI));
				it.flag               = 1'($urandom_range(0, 1));
				it.temperature_tenths = 10'($urandom_range(0, 1023));
				it.minutes            = 6'($urandom_range(0, 63));
				it.hours              = 5'($urandom_range(0, 31));
				it.command_code       = 8'($urandom_range(0, 255));
				send_item(it, 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;

		drain_frames();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_beats.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
